// ===== rtl/bxavg_pkg.sv =====
// bxavg_pkg: shared widths and reset constants for the box average downsampler.
// No dependencies; used by every module under rtl/ except bxavg_fifo.
package bxavg_pkg;

	localparam int unsigned SAMPLE_W = 16;  // sample and average word width
	localparam int unsigned CFG_W    = 9;   // group size register width

	localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 9'd4;

endpackage

// ===== rtl/box_average_downsample.sv =====
// box_average_downsample: top level of the box-filter average downsampler.
// Depends on bxavg_pkg, bxavg_front, bxavg_fifo and bxavg_div.
//
//  port group       | dir | handshake                      | word
//  -----------------+-----+--------------------------------+-----------------------
//  sample           | in  | sample_valid / sample_stall    | sample[15:0]
//  average          | out | average_valid / average_stall  | average[15:0]
//  group_size       | in  | group_size_wr (no wait)        | group_size[8:0]
//
//  Flow: the front takes one sample word per cycle unless the queue is full.
//  Each closed group goes through a shift-subtract divider at one quotient
//  bit per cycle; a two-entry queue absorbs bursts, so groups with at least
//  as many samples as a division takes cycles stream at full rate.
//  Reset (arst_n low, asynchronous) clears the sum, count, queue and divider
//  and sets the group size to 4. Stall on sample only rises while the queue
//  is full; a result waits in the output register while the divider goes on.
module box_average_downsample #(
	parameter int unsigned MAX_GROUP = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           group_size_wr,
	input  logic [bxavg_pkg::CFG_W-1:0]    group_size,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic [bxavg_pkg::SAMPLE_W-1:0] sample,
	output logic                           average_valid,
	input  logic                           average_stall,
	output logic [bxavg_pkg::SAMPLE_W-1:0] average
);

	// effective group size never exceeds MAX_GROUP or the 9-bit register
	localparam int unsigned SIZE_CAP =
		(MAX_GROUP < (1 << bxavg_pkg::CFG_W)) ? MAX_GROUP : ((1 << bxavg_pkg::CFG_W) - 1);
	localparam int unsigned SIZE_W   = $clog2(SIZE_CAP + 1);
	localparam int unsigned SUM_W    = bxavg_pkg::SAMPLE_W + $clog2(SIZE_CAP + 1);
	localparam int unsigned ENTRY_W  = SUM_W + SIZE_W;

	logic                 grp_push;
	logic [SUM_W-1:0]     front_sum;
	logic [SIZE_W-1:0]    front_size;
	logic                 queue_full;
	logic                 queue_not_empty;
	logic                 queue_pop;
	logic [ENTRY_W-1:0]   queue_out;

	bxavg_front #(
		.MAX_GROUP (SIZE_CAP),
		.SIZE_W    (SIZE_W),
		.SUM_W     (SUM_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.group_size_wr (group_size_wr),
		.group_size    (group_size),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.grp_push      (grp_push),
		.grp_sum       (front_sum),
		.grp_size      (front_size),
		.queue_full    (queue_full)
	);

	bxavg_fifo #(
		.DATA_W (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (grp_push),
		.push_data ({front_sum, front_size}),
		.full      (queue_full),
		.pop       (queue_pop),
		.not_empty (queue_not_empty),
		.pop_data  (queue_out)
	);

	bxavg_div #(
		.SIZE_W (SIZE_W),
		.SUM_W  (SUM_W)
	) u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.grp_ready     (queue_not_empty),
		.grp_sum       (queue_out[ENTRY_W-1:SIZE_W]),
		.grp_size      (queue_out[SIZE_W-1:0]),
		.grp_pop       (queue_pop),
		.average_valid (average_valid),
		.average_stall (average_stall),
		.average       (average)
	);

endmodule

// ===== rtl/bxavg_fifo.sv =====
// bxavg_fifo: two-entry queue between the accumulator front and the divider back.
// Depends on nothing; data width is a parameter.
module bxavg_fifo #(
	parameter int unsigned DATA_W = 33
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output logic [DATA_W-1:0] pop_data
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        fill_q;

	logic do_push;
	logic do_pop;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== rtl/bxavg_front.sv =====
// bxavg_front: group size register, running sum and sample counter.
// Depends on bxavg_pkg; hands each closed group (sum, size) to the queue.
module bxavg_front #(
	parameter int unsigned MAX_GROUP = 256,
	parameter int unsigned SIZE_W    = 9,
	parameter int unsigned SUM_W     = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           group_size_wr,
	input  logic [bxavg_pkg::CFG_W-1:0]    group_size,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic [bxavg_pkg::SAMPLE_W-1:0] sample,
	output logic                           grp_push,
	output logic [SUM_W-1:0]               grp_sum,
	output logic [SIZE_W-1:0]              grp_size,
	input  logic                           queue_full
);

	localparam int unsigned RESET_SIZE =
		(32'(bxavg_pkg::GROUP_SIZE_RESET) > MAX_GROUP) ? MAX_GROUP
		: 32'(bxavg_pkg::GROUP_SIZE_RESET);

	logic [SIZE_W-1:0] eff_size_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SIZE_W-1:0] count_q;

	logic [31:0]       wr_size32;
	logic [SIZE_W-1:0] wr_eff;
	logic              take;
	logic [SUM_W-1:0]  sum_next;
	logic [SIZE_W-1:0] count_next;
	logic              closes;

	// zero means one, anything above MAX_GROUP saturates
	always_comb begin
		wr_size32 = 32'(group_size);
		if (wr_size32 == 32'd0) begin
			wr_eff = SIZE_W'(1);
		end else if (wr_size32 > MAX_GROUP) begin
			wr_eff = SIZE_W'(MAX_GROUP);
		end else begin
			wr_eff = SIZE_W'(wr_size32);
		end
	end

	assign sample_stall = queue_full;
	assign take         = sample_valid && !sample_stall;
	assign sum_next     = sum_q + SUM_W'(sample);
	assign count_next   = count_q + SIZE_W'(1);
	assign closes       = (count_next == eff_size_q);

	assign grp_push = take && closes;
	assign grp_sum  = sum_next;
	assign grp_size = eff_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_size_q <= SIZE_W'(RESET_SIZE);
			sum_q      <= '0;
			count_q    <= '0;
		end else if (group_size_wr) begin
			// a write drops any partial group
			eff_size_q <= wr_eff;
			sum_q      <= '0;
			count_q    <= '0;
		end else if (take) begin
			if (closes) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= count_next;
			end
		end
	end

endmodule

// ===== rtl/bxavg_div.sv =====
// bxavg_div: restoring divider, one quotient bit per cycle, plus the output register.
// Depends on bxavg_pkg; pulls (sum, size) pairs from the queue.
module bxavg_div #(
	parameter int unsigned SIZE_W = 9,
	parameter int unsigned SUM_W  = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           grp_ready,
	input  logic [SUM_W-1:0]               grp_sum,
	input  logic [SIZE_W-1:0]              grp_size,
	output logic                           grp_pop,
	output logic                           average_valid,
	input  logic                           average_stall,
	output logic [bxavg_pkg::SAMPLE_W-1:0] average
);

	localparam int unsigned STEP_W = $clog2(SUM_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [SUM_W-1:0]                dvd_q;    // dividend in, quotient out
	logic [SIZE_W-1:0]               dvs_q;
	logic [SIZE_W-1:0]               rem_q;
	logic [STEP_W-1:0]               step_q;
	logic                            out_valid_q;
	logic [bxavg_pkg::SAMPLE_W-1:0]  average_q;

	logic [SIZE_W:0] rem_sh;
	logic            ge;
	logic [SIZE_W:0] rem_sub;
	logic            out_free;

	assign rem_sh   = {rem_q, dvd_q[SUM_W-1]};
	assign ge       = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub  = rem_sh - {1'b0, dvs_q};
	assign out_free = !out_valid_q || !average_stall;

	assign grp_pop       = (state_q == ST_IDLE) && grp_ready;
	assign average_valid = out_valid_q;
	assign average       = average_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dvd_q       <= '0;
			dvs_q       <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			average_q   <= '0;
		end else begin
			// a new word loads as the old one leaves, otherwise valid drops on accept
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !average_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (grp_ready) begin
						dvd_q   <= grp_sum;
						dvs_q   <= grp_size;
						rem_q   <= '0;
						step_q  <= STEP_W'(SUM_W - 1);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					rem_q <= ge ? rem_sub[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
					dvd_q <= {dvd_q[SUM_W-2:0], ge};
					if (step_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_FINISH: begin
					// sum <= size * 0xFFFF, so the quotient fits the sample width
					if (out_free) begin
						average_q <= dvd_q[bxavg_pkg::SAMPLE_W-1:0];
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/average_checker.sv =====
`timescale 1ns / 100ps
// average_checker: watches the sample, average and group size ports of the box
// average downsampler, predicts each average word and compares it. Uses bxavg_pkg.
module average_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           group_size_wr,
	input  logic [bxavg_pkg::CFG_W-1:0]    group_size,
	input  logic                           sample_valid,
	input  logic                           sample_stall,
	input  logic [bxavg_pkg::SAMPLE_W-1:0] sample,
	input  logic                           average_valid,
	input  logic                           average_stall,
	input  logic [bxavg_pkg::SAMPLE_W-1:0] average,
	output int                             mismatches,
	output int                             pending
);

	localparam int unsigned CFG_W    = bxavg_pkg::CFG_W;
	localparam int unsigned SAMPLE_W = bxavg_pkg::SAMPLE_W;

	logic [CFG_W-1:0]    size_reg;
	logic [23:0]         run_sum;
	logic [CFG_W-1:0]    run_count;
	logic [SAMPLE_W-1:0] averages_due[$];

	// zero acts as one, anything past 256 saturates
	function automatic logic [CFG_W-1:0] group_divisor(input logic [CFG_W-1:0] raw);
		if (raw == '0)
			return 9'd1;
		if (raw > 9'd256)
			return 9'd256;
		return raw;
	endfunction

	task automatic flag(input string what, input logic [SAMPLE_W-1:0] want,
			input logic [SAMPLE_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [CFG_W-1:0] div;
		logic [23:0]      quo;
		if (!arst_n) begin
			size_reg   = bxavg_pkg::GROUP_SIZE_RESET;
			run_sum    = '0;
			run_count  = '0;
			averages_due.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (average_valid && !average_stall) begin
				if (averages_due.size() == 0)
					flag("average word with nothing due", 'x, average);
				else if (average !== averages_due[0]) begin
					flag("average mismatch", averages_due[0], average);
					void'(averages_due.pop_front());
				end else
					void'(averages_due.pop_front());
			end
			// a write drops whatever partial group is in flight
			if (group_size_wr) begin
				size_reg  = group_size;
				run_sum   = '0;
				run_count = '0;
			end
			if (sample_valid && !sample_stall) begin
				div       = group_divisor(size_reg);
				run_sum   = run_sum + sample;
				run_count = run_count + 1'b1;
				if (run_count >= div) begin
					quo = run_sum / div;
					averages_due.push_back(quo > 24'hFFFF ? 16'hFFFF : quo[SAMPLE_W-1:0]);
					run_sum   = '0;
					run_count = '0;
				end
			end
			pending = averages_due.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for box_average_downsample.
// Depends on bxavg_pkg, the RTL under rtl/ and average_checker.
module tb_top;

	localparam int unsigned CFG_W    = bxavg_pkg::CFG_W;
	localparam int unsigned SAMPLE_W = bxavg_pkg::SAMPLE_W;

	// divider holds one group while the queue holds two more
	localparam int SETTLE    = 100;
	localparam int MAX_CYCLE = 1_000_000;

	logic                clk;
	logic                arst_n;
	logic                group_size_wr;
	logic [CFG_W-1:0]    group_size;
	logic                sample_valid;
	logic                sample_stall;
	logic [SAMPLE_W-1:0] sample;
	logic                average_valid;
	logic                average_stall;
	logic [SAMPLE_W-1:0] average;

	int  mismatches;
	int  pending;
	int  cycle_count;
	bit  steady_src;   // source sends back to back while set
	bit  steady_sink;  // sink never stalls while set

	box_average_downsample dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.group_size_wr(group_size_wr),
		.group_size   (group_size),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.average_valid(average_valid),
		.average_stall(average_stall),
		.average      (average)
	);

	average_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.group_size_wr(group_size_wr),
		.group_size   (group_size),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.average_valid(average_valid),
		.average_stall(average_stall),
		.average      (average),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop in case a word never shows up
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLE) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Gap before a sample word: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_src || r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// 8-bit content, deep color content, and the two rails
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 5)
			return SAMPLE_W'($urandom_range(0, 255));
		return SAMPLE_W'($urandom);
	endfunction

	// Called at a falling edge; returns at the falling edge after the word
	// was taken, with valid still high so back-to-back words need no toggle.
	task automatic send_word(input logic [SAMPLE_W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample       <= v;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
	endtask

	// Registers only change with nothing in flight; any partial group is
	// dropped by the block, which the checker models too.
	task automatic write_group_size(input logic [CFG_W-1:0] v);
		sample_valid <= 1'b0;
		drain();
		repeat (SETTLE) @(negedge clk);
		group_size_wr <= 1'b1;
		group_size    <= v;
		@(negedge clk);
		group_size_wr <= 1'b0;
		group_size    <= CFG_W'($urandom);
		@(negedge clk);
	endtask

	// Sink stall pattern: a mix of short and long stalls, with quiet
	// stretches picked now and then.
	initial begin
		int r;
		int len;
		int cnt;
		average_stall = 1'b0;
		steady_sink   = 1'b0;
		cnt           = 0;
		forever begin
			@(negedge clk);
			cnt++;
			if (cnt % 300 == 0)
				steady_sink = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (steady_sink || r < 65)
				average_stall <= 1'b0;
			else begin
				average_stall <= 1'b1;
				len = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 50);
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	// Phases: group size, number of words. Counts that are not a
	// multiple of the size leave a partial group for the next write to drop.
	logic [CFG_W-1:0] phase_size[12] = '{9'd1, 9'd0, 9'd2, 9'd3, 9'd7, 9'd16,
			9'd37, 9'd256, 9'd511, 9'd5, 9'd0, 9'd4};
	int phase_len[12] = '{60, 30, 31, 32, 40, 32, 74, 256, 258, 25, 0, 24};

	initial begin
		logic [SAMPLE_W-1:0] directed[24] = '{
			16'h0000, 16'h0000, 16'h0000, 16'h0000,  // all zero
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,  // all max
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE,  // floor just below max
			16'h0001, 16'h0002, 16'h0003, 16'h0005,  // floor drops a remainder
			16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,  // alternating bits
			16'h00FF, 16'h00FE, 16'h00FF, 16'h8000   // 8-bit words, top bit
		};
		logic [CFG_W-1:0] sz;

		arst_n        = 1'b0;
		group_size_wr = 1'b0;
		group_size    = '0;
		sample_valid  = 1'b0;
		sample        = '0;
		steady_src    = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset group size of four, directed words
		foreach (directed[i])
			send_word(directed[i]);

		// size zero acts as one: each word is its own average
		write_group_size('0);
		send_word('1);
		send_word(16'h1234);
		send_word('0);

		for (int p = 0; p < 12; p++) begin
			// slot 10 picks a random size, with a random number of words
			if (phase_len[p] == 0) begin
				sz = CFG_W'($urandom_range(1, 64));
				phase_len[p] = $urandom_range(20, 50);
			end else
				sz = phase_size[p];
			write_group_size(sz);
			steady_src = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < phase_len[p]; i++) begin
				// hold off mid-phase until the pipe is empty
				if (p == 0 && i == 50) begin
					sample_valid <= 1'b0;
					drain();
				end
				// largest group filled with max words: biggest possible sum
				if (sz == 9'd256 && i < 256)
					send_word('1);
				else
					send_word(pick_sample());
			end
		end
		sample_valid <= 1'b0;

		drain();
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bxavg_pkg.sv
rtl/bxavg_fifo.sv
rtl/bxavg_front.sv
rtl/bxavg_div.sv
rtl/box_average_downsample.sv
tb/average_checker.sv
tb/tb_top.sv
